// File: rtl/pvo_pkg.sv
// Package for the position/velocity observer: control word layout, field codes,
// register indexes and the microcode program. No dependencies.
package pvo_pkg;

    localparam int MEAS_W  = 32;
    localparam int DT_W    = 24;
    localparam int GAIN_W  = 32;
    localparam int EST_W   = 32;
    localparam int OPD_W   = 34;   // error / scaled error operand
    localparam int MULB_W  = 25;   // time step or one gain half, zero-extended
    localparam int PROD_W  = OPD_W + MULB_W;
    localparam int ACC_W   = 52;
    localparam int STEP_W  = 4;

    localparam logic [STEP_W-1:0] STEP_LAST = 4'd13;

    // configuration register indexes
    localparam logic CFG_POSITION_GAIN = 1'b0;
    localparam logic CFG_VELOCITY_GAIN = 1'b1;

    // multiplier A operand
    localparam logic A_VEL = 1'b0;
    localparam logic A_OPD = 1'b1;

    // multiplier B operand
    localparam logic [2:0] B_DT    = 3'd0;
    localparam logic [2:0] B_PG_HI = 3'd1;
    localparam logic [2:0] B_PG_LO = 3'd2;
    localparam logic [2:0] B_VG_HI = 3'd3;
    localparam logic [2:0] B_VG_LO = 3'd4;

    // operand register update
    localparam logic [1:0] OPD_HOLD  = 2'd0;
    localparam logic [1:0] OPD_ERR   = 2'd1;
    localparam logic [1:0] OPD_RND24 = 2'd2;

    // accumulator update
    localparam logic [2:0] ACC_HOLD      = 3'd0;
    localparam logic [2:0] ACC_POS_RND24 = 3'd1;
    localparam logic [2:0] ACC_LOAD_VEL  = 3'd2;
    localparam logic [2:0] ACC_ADD_PROD  = 3'd3;
    localparam logic [2:0] ACC_ADD_RND16 = 3'd4;

    // estimate write-back
    localparam logic [1:0] EST_NONE = 2'd0;
    localparam logic [1:0] EST_POS  = 2'd1;
    localparam logic [1:0] EST_VEL  = 2'd2;

    typedef struct packed {
        logic       a_sel;
        logic [2:0] b_sel;
        logic [1:0] opd_op;
        logic [2:0] acc_op;
        logic [1:0] est_wr;
        logic       wait_out;   // hold here while the output slot is full
        logic       last;       // end of program, emit the item
    } ctl_t;

    localparam ctl_t CTL_NOP = '{a_sel: A_VEL, b_sel: B_DT, opd_op: OPD_HOLD,
                                 acc_op: ACC_HOLD, est_wr: EST_NONE,
                                 wait_out: 1'b0, last: 1'b0};

    function automatic ctl_t mk(logic a, logic [2:0] b, logic [1:0] o,
                                logic [2:0] acc, logic [1:0] e, logic fin);
        ctl_t c;
        c.a_sel    = a;
        c.b_sel    = b;
        c.opd_op   = o;
        c.acc_op   = acc;
        c.est_wr   = e;
        c.wait_out = fin;
        c.last     = fin;
        return c;
    endfunction

    // Observer program. While the program advances, the product register holds the product
    // issued by the previous step.
    function automatic ctl_t pvo_ucode(logic [STEP_W-1:0] step);
        ctl_t c;
        case (step)
            4'd0:    c = mk(A_VEL, B_DT,    OPD_ERR,   ACC_HOLD,      EST_NONE, 1'b0);
            4'd1:    c = mk(A_OPD, B_DT,    OPD_HOLD,  ACC_POS_RND24, EST_NONE, 1'b0);
            4'd2:    c = mk(A_OPD, B_DT,    OPD_RND24, ACC_HOLD,      EST_NONE, 1'b0);
            4'd3:    c = mk(A_OPD, B_PG_HI, OPD_HOLD,  ACC_HOLD,      EST_NONE, 1'b0);
            4'd4:    c = mk(A_OPD, B_PG_LO, OPD_HOLD,  ACC_ADD_PROD,  EST_NONE, 1'b0);
            4'd5:    c = mk(A_OPD, B_DT,    OPD_HOLD,  ACC_ADD_RND16, EST_NONE, 1'b0);
            4'd6:    c = mk(A_OPD, B_DT,    OPD_HOLD,  ACC_HOLD,      EST_POS,  1'b0);
            4'd7:    c = mk(A_OPD, B_DT,    OPD_ERR,   ACC_HOLD,      EST_NONE, 1'b0);
            4'd8:    c = mk(A_OPD, B_DT,    OPD_HOLD,  ACC_LOAD_VEL,  EST_NONE, 1'b0);
            4'd9:    c = mk(A_OPD, B_DT,    OPD_RND24, ACC_HOLD,      EST_NONE, 1'b0);
            4'd10:   c = mk(A_OPD, B_VG_HI, OPD_HOLD,  ACC_HOLD,      EST_NONE, 1'b0);
            4'd11:   c = mk(A_OPD, B_VG_LO, OPD_HOLD,  ACC_ADD_PROD,  EST_NONE, 1'b0);
            4'd12:   c = mk(A_OPD, B_DT,    OPD_HOLD,  ACC_ADD_RND16, EST_NONE, 1'b0);
            4'd13:   c = mk(A_OPD, B_DT,    OPD_HOLD,  ACC_HOLD,      EST_VEL,  1'b1);
            default: c = CTL_NOP;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/pvo_datapath.sv
// Observer datapath: estimates, operand, shared multiplier and accumulator,
// steered by one control word a cycle. Depends on pvo_pkg.
module pvo_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pvo_pkg::ctl_t                 ctl,
    input  logic                          load,
    input  logic [pvo_pkg::MEAS_W-1:0]    meas_in,
    input  logic [pvo_pkg::DT_W-1:0]      dt_in,
    input  logic [pvo_pkg::GAIN_W-1:0]    position_gain,
    input  logic [pvo_pkg::GAIN_W-1:0]    velocity_gain,
    output logic [pvo_pkg::EST_W-1:0]     pos_est,
    output logic [pvo_pkg::EST_W-1:0]     acc_sat
);
    import pvo_pkg::*;

    logic [EST_W-1:0]         pos_reg, pos_next;
    logic [EST_W-1:0]         vel_reg, vel_next;
    logic [MEAS_W-1:0]        meas_reg;
    logic [DT_W-1:0]          dt_reg;
    logic [OPD_W-1:0]         opd_reg, opd_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;

    logic signed [OPD_W-1:0]  a_op;
    logic signed [MULB_W-1:0] b_op;
    logic [PROD_W-1:0]        prod_r24, prod_r16;
    logic [OPD_W-1:0]         err;

    // operand select
    always_comb
    begin
        a_op = (ctl.a_sel == A_OPD) ? $signed(opd_reg)
                                    : $signed({{(OPD_W-EST_W){vel_reg[EST_W-1]}}, vel_reg});
        case (ctl.b_sel)
            B_PG_HI: b_op = $signed({9'd0, position_gain[31:16]});
            B_PG_LO: b_op = $signed({9'd0, position_gain[15:0]});
            B_VG_HI: b_op = $signed({9'd0, velocity_gain[31:16]});
            B_VG_LO: b_op = $signed({9'd0, velocity_gain[15:0]});
            default: b_op = $signed({1'b0, dt_reg});
        endcase
    end

    assign prod_next = a_op * b_op;

    // round half up, then drop the fraction bits
    assign prod_r24 = prod_reg + PROD_W'(24'h80_0000);
    assign prod_r16 = prod_reg + PROD_W'(16'h8000);

    assign err = {{(OPD_W-MEAS_W){meas_reg[MEAS_W-1]}}, meas_reg}
               - {{(OPD_W-EST_W){pos_reg[EST_W-1]}}, pos_reg};

    // clamp the accumulator to the signed 32-bit range
    always_comb
    begin
        if (&acc_reg[ACC_W-1:EST_W-1] || ~|acc_reg[ACC_W-1:EST_W-1])
            acc_sat = acc_reg[EST_W-1:0];
        else if (acc_reg[ACC_W-1])
            acc_sat = {1'b1, {(EST_W-1){1'b0}}};
        else
            acc_sat = {1'b0, {(EST_W-1){1'b1}}};
    end

    always_comb
    begin
        case (ctl.opd_op)
            OPD_ERR:   opd_next = err;
            OPD_RND24: opd_next = prod_r24[OPD_W+23:24];
            default:   opd_next = opd_reg;
        endcase

        case (ctl.acc_op)
            ACC_POS_RND24: acc_next = {{(ACC_W-EST_W){pos_reg[EST_W-1]}}, pos_reg}
                                    + {{(ACC_W-(PROD_W-24)){prod_r24[PROD_W-1]}},
                                       prod_r24[PROD_W-1:24]};
            ACC_LOAD_VEL:  acc_next = {{(ACC_W-EST_W){vel_reg[EST_W-1]}}, vel_reg};
            ACC_ADD_PROD:  acc_next = acc_reg + prod_reg[ACC_W-1:0];
            ACC_ADD_RND16: acc_next = acc_reg
                                    + {{(ACC_W-(PROD_W-16)){prod_r16[PROD_W-1]}},
                                       prod_r16[PROD_W-1:16]};
            default:       acc_next = acc_reg;
        endcase

        pos_next = (ctl.est_wr == EST_POS) ? acc_sat : pos_reg;
        vel_next = (ctl.est_wr == EST_VEL) ? acc_sat : vel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            vel_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            vel_reg <= vel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            meas_reg <= meas_in;
            dt_reg   <= dt_in;
        end
        opd_reg  <= opd_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign pos_est = pos_reg;

endmodule

// File: rtl/position_velocity_observer.sv
// Top level of the second-order position/velocity observer: stream ports,
// gain registers, microcode sequencer and output slot. Depends on pvo_pkg, pvo_datapath.
//
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+----------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | measured_position, time_step
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | velocity_estimate, position_estimate
//  cfg       | in        | cfg_wr_en (no wait)           | cfg_index selects gain, cfg_data
//
// Each item is accepted, then a 14-step program puts
// every multiply through a single shared 34x25 signed multiplier.
// Reset clears both estimates and both gains; the block is ready right after reset.
// A finished item sits in the output register; the next item is accepted and
// computed meanwhile, and only the final step holds while that register is full.
module position_velocity_observer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // [31:0] measured_position, [55:32] time_step
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] velocity_estimate, [63:32] position_estimate
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import pvo_pkg::*;

    logic               busy_reg, busy_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [GAIN_W-1:0]  pgain_reg, pgain_next;
    logic [GAIN_W-1:0]  vgain_reg, vgain_next;
    logic               out_valid_reg, out_valid_next;
    logic [63:0]        out_data_reg, out_data_next;

    ctl_t               ctl_rom;
    ctl_t               ctl_dp;
    logic               accept;
    logic               slot_full;
    logic               advance;
    logic               emit;
    logic [EST_W-1:0]   pos_est;
    logic [EST_W-1:0]   acc_sat;

    assign s_axis_tready = !busy_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Fetch the control word; the final step waits on a full output slot.
    assign ctl_rom   = pvo_ucode(step_reg);
    assign slot_full = out_valid_reg && !m_axis_tready;
    assign advance   = busy_reg && !(ctl_rom.wait_out && slot_full);
    assign ctl_dp    = advance ? ctl_rom : CTL_NOP;
    assign emit      = advance && ctl_rom.last;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (emit)
        begin
            busy_next = 1'b0;
            step_next = '0;
        end
        else if (advance)
        begin
            step_next = step_reg + STEP_W'(1);
        end

        // gain writes
        pgain_next = pgain_reg;
        vgain_next = vgain_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_POSITION_GAIN: pgain_next = cfg_data;
                CFG_VELOCITY_GAIN: vgain_next = cfg_data;
                default:           pgain_next = pgain_reg;
            endcase
        end

        // output slot: load on emit, drop once taken
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {pos_est, acc_sat};
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            pgain_reg     <= '0;
            vgain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            pgain_reg     <= pgain_next;
            vgain_reg     <= vgain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    pvo_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl_dp),
        .load          (accept),
        .meas_in       (s_axis_tdata[31:0]),
        .dt_in         (s_axis_tdata[55:32]),
        .position_gain (pgain_reg),
        .velocity_gain (vgain_reg),
        .pos_est       (pos_est),
        .acc_sat       (acc_sat)
    );

    // program counter never runs past the final step
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg <= STEP_LAST))
        else $error("observer step counter past end of program");

    // an accepted item starts the program from the first step
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy_reg && step_reg == '0))
        else $error("observer did not start program after accept");

    // an item is emitted only into a free or draining output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !slot_full)
        else $error("observer overwrote a pending output item");

    // output valid rises only at the end of the program
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(busy_reg) && $past(step_reg) == STEP_LAST))
        else $error("observer output appeared without finishing the program");

endmodule
